// File: sv/sorted_hash_table_lookup_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted hash table lookup assertion macros
// Immediate-consequence and next-cycle checks on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_HASH_TABLE_LOOKUP_UNIT_ASSERT_SVH
`define SORTED_HASH_TABLE_LOOKUP_UNIT_ASSERT_SVH

`define SHLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define SHLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/shlu_pkg.sv
// ----------------------------------------------------------------------------
// Sorted hash table lookup package
// Field widths, codes and the types used by the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package shlu_pkg;

  localparam int unsigned SLOT_W  = 17;
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned KH_W    = 32;
  localparam int unsigned KM_W    = 64;
  localparam int unsigned KL_W    = 64;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

  typedef struct packed {
    logic [KH_W-1:0]  hi;
    logic [KM_W-1:0]  mid;
    logic [KL_W-1:0]  lo;
    logic [IDX_W-1:0] idx;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UP_RD,
    ST_UP_CHK,
    ST_DN_RD,
    ST_DN_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic ld_start;
    logic rst_ptr;
    logic rd_up;
    logic rd_dn;
    logic set_hit;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic acc_lookup;
    logic count_zero;
    logic ptr_end;
    logic ptr_zero;
    logic hi_gt;
    logic hi_lt;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/shlu_if.sv
// ----------------------------------------------------------------------------
// Sorted hash table lookup channels
// Request and response word channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface shlu_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [shlu_pkg::SLOT_W-1:0]   slot;
  logic [shlu_pkg::IDX_W-1:0]    entry_index;
  logic [shlu_pkg::KH_W-1:0]     key_high;
  logic [shlu_pkg::KM_W-1:0]     key_mid;
  logic [shlu_pkg::KL_W-1:0]     key_low;

  modport source (output valid, cmd, slot, entry_index, key_high, key_mid, key_low,
                  input ready);
  modport sink (input valid, cmd, slot, entry_index, key_high, key_mid, key_low,
                output ready);
endinterface

interface shlu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [shlu_pkg::IDX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink (input valid, found, match_index, output ready);
endinterface

`default_nettype wire

// File: sv/shlu_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted hash table lookup controller
// Sequences loads, the interpolation start, the upward and downward scans and the response handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module shlu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shlu_pkg::sts_t  sts_i,
  output shlu_pkg::ctl_t  ctl_o
);

  shlu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shlu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      shlu_pkg::ST_IDLE: begin
        if (sts_i.accept) begin
          if (!sts_i.acc_lookup || sts_i.count_zero) begin
            state_d = shlu_pkg::ST_DONE;
          end else begin
            state_d = shlu_pkg::ST_MUL;
          end
        end
      end
      shlu_pkg::ST_MUL: begin
        state_d = shlu_pkg::ST_UP_RD;
      end
      shlu_pkg::ST_UP_RD: begin
        state_d = sts_i.ptr_end ? shlu_pkg::ST_DN_RD : shlu_pkg::ST_UP_CHK;
      end
      shlu_pkg::ST_UP_CHK: begin
        if (sts_i.hit) begin
          state_d = shlu_pkg::ST_DONE;
        end else if (sts_i.hi_gt) begin
          state_d = shlu_pkg::ST_DN_RD;
        end else begin
          state_d = shlu_pkg::ST_UP_RD;
        end
      end
      shlu_pkg::ST_DN_RD: begin
        state_d = sts_i.ptr_zero ? shlu_pkg::ST_DONE : shlu_pkg::ST_DN_CHK;
      end
      shlu_pkg::ST_DN_CHK: begin
        if (sts_i.hit || sts_i.hi_lt) begin
          state_d = shlu_pkg::ST_DONE;
        end else begin
          state_d = shlu_pkg::ST_DN_RD;
        end
      end
      shlu_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = shlu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = shlu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o = '0;
    case (state_q)
      shlu_pkg::ST_IDLE: begin
        ctl_o.in_ready = 1'b1;
      end
      shlu_pkg::ST_MUL: begin
        ctl_o.ld_start = 1'b1;
      end
      shlu_pkg::ST_UP_RD: begin
        ctl_o.rst_ptr = sts_i.ptr_end;
        ctl_o.rd_up   = !sts_i.ptr_end;
      end
      shlu_pkg::ST_UP_CHK: begin
        ctl_o.set_hit = sts_i.hit;
        ctl_o.rst_ptr = !sts_i.hit && sts_i.hi_gt;
      end
      shlu_pkg::ST_DN_RD: begin
        ctl_o.rd_dn = !sts_i.ptr_zero;
      end
      shlu_pkg::ST_DN_CHK: begin
        ctl_o.set_hit = sts_i.hit;
      end
      shlu_pkg::ST_DONE: begin
        ctl_o.out_load = sts_i.out_free;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/shlu_datapath.sv
// ----------------------------------------------------------------------------
// Sorted hash table lookup datapath
// Slot memory, start interpolation, probe pointer, compare and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module shlu_datapath #(
  parameter int unsigned TABLE_DEPTH = 131072
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [shlu_pkg::CNT_W-1:0]    entry_count_i,
  input  shlu_pkg::ctl_t                ctl_i,
  output shlu_pkg::sts_t                sts_o,
  shlu_req_if.sink                      req_i,
  shlu_rsp_if.source                    rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = CW + shlu_pkg::KH_W;

  shlu_pkg::slot_t mem_q [TABLE_DEPTH];
  shlu_pkg::slot_t rd_q;
  shlu_pkg::slot_t wr_word;

  logic                       accept;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic                       rd_en;
  logic [CW-1:0]              count_c;
  logic [CW-1:0]              count_q;
  logic [PW-1:0]              prod_q;
  logic [CW-1:0]              start_q;
  logic [CW-1:0]              ptr_q, ptr_d;
  logic [CW-1:0]              ptr_dec;
  logic [shlu_pkg::KH_W-1:0]  kh_q;
  logic [shlu_pkg::KM_W-1:0]  km_q;
  logic [shlu_pkg::KL_W-1:0]  kl_q;
  logic                       found_q;
  logic [shlu_pkg::IDX_W-1:0] idx_q;
  logic                       rsp_found_q;
  logic [shlu_pkg::IDX_W-1:0] rsp_idx_q;
  logic                       out_valid_q, out_valid_d;

  assign accept      = req_i.valid && ctl_i.in_ready;
  assign req_i.ready = ctl_i.in_ready;

  assign count_c = (32'(entry_count_i) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(entry_count_i);

  assign wr_en   = accept && (req_i.cmd == shlu_pkg::CMD_LOAD)
                   && (32'(req_i.slot) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(req_i.slot);
  assign wr_word = '{hi: req_i.key_high, mid: req_i.key_mid, lo: req_i.key_low,
                     idx: req_i.entry_index};

  assign ptr_dec = ptr_q - CW'(1);
  assign rd_en   = ctl_i.rd_up || ctl_i.rd_dn;
  assign rd_addr = ctl_i.rd_dn ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.ld_start) begin
      ptr_d = prod_q[PW-1:shlu_pkg::KH_W];
    end else if (ctl_i.rst_ptr) begin
      ptr_d = start_q;
    end else if (ctl_i.rd_up) begin
      ptr_d = ptr_q + CW'(1);
    end else if (ctl_i.rd_dn) begin
      ptr_d = ptr_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (accept) begin
      kh_q    <= req_i.key_high;
      km_q    <= req_i.key_mid;
      kl_q    <= req_i.key_low;
      count_q <= count_c;
      prod_q  <= PW'(count_c) * PW'(req_i.key_high);
      found_q <= 1'b0;
      idx_q   <= '0;
    end else if (ctl_i.set_hit) begin
      found_q <= 1'b1;
      idx_q   <= rd_q.idx;
    end
    if (ctl_i.ld_start) begin
      start_q <= prod_q[PW-1:shlu_pkg::KH_W];
    end
    if (ctl_i.out_load) begin
      rsp_found_q <= found_q;
      rsp_idx_q   <= idx_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.match_index = rsp_idx_q;

  assign sts_o.accept     = accept;
  assign sts_o.acc_lookup = (req_i.cmd == shlu_pkg::CMD_LOOKUP);
  assign sts_o.count_zero = (count_c == '0);
  assign sts_o.ptr_end    = (ptr_q >= count_q);
  assign sts_o.ptr_zero   = (ptr_q == '0);
  assign sts_o.hi_gt      = (rd_q.hi > kh_q);
  assign sts_o.hi_lt      = (rd_q.hi < kh_q);
  assign sts_o.hit        = (rd_q.hi == kh_q) && (rd_q.mid == km_q) && (rd_q.lo == kl_q);
  assign sts_o.out_free   = !out_valid_q || rsp_o.ready;

endmodule

`default_nettype wire

// File: sv/sorted_hash_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// Sorted hash table lookup unit
// Looks up 160-bit hashes in a table kept sorted by the high hash word.
//
// The request channel carries load words, which write one table slot, and
// lookup words, which search the table. Every request gives exactly one word
// on the response channel: found and the stored entry index, or zero.
// entry_count is to be written over the APB port only while the unit is idle;
// the unit itself does not enforce this. A load, or a lookup with entry_count
// zero, goes from idle to the done state, which loads its response word into
// the output register; the next request is taken back in idle. A lookup
// starts at slot entry_count*key_high/2^32 and probes one slot at a time, each
// in a read state and a check state around the table memory's registered
// read, first upward from the start slot and then downward below it; the
// next request is taken once the done state has handed over its word. One
// request is in work at a time. The response sits in an output register, so
// the next request is taken while a finished word waits; a stalled receiver
// holds the unit in its done state once a second result is ready. Reset clears
// entry_count and the control state; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_hash_table_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 131072
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  shlu_req_if.sink                       req_i,
  shlu_rsp_if.source                     rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [shlu_pkg::PADDR_W-1:0]   paddr,
  input  logic [shlu_pkg::PDATA_W-1:0]   pwdata,
  output logic [shlu_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [shlu_pkg::CNT_W-1:0] entry_count_q, entry_count_d;
  logic                       reg_sel;
  shlu_pkg::ctl_t             ctl;
  shlu_pkg::sts_t             sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[shlu_pkg::PADDR_W-1:2] == shlu_pkg::REG_ENTRY_COUNT);
  assign prdata  = reg_sel ? shlu_pkg::PDATA_W'(entry_count_q) : '0;

  always_comb begin
    entry_count_d = entry_count_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      entry_count_d = pwdata[shlu_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else begin
      entry_count_q <= entry_count_d;
    end
  end

  shlu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  shlu_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_count_i (entry_count_q),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .req_i         (req_i),
    .rsp_o         (rsp_o)
  );

`include "sorted_hash_table_lookup_unit_assert.svh"

  `SHLU_ASSERT_NOW(a_up_read_in_range, ctl.rd_up, !sts.ptr_end, "upward probe at or past count")
  `SHLU_ASSERT_NOW(a_dn_read_in_range, ctl.rd_dn, !sts.ptr_zero, "downward probe below slot zero")
  `SHLU_ASSERT_NOW(a_miss_zero, rsp_o.valid && !rsp_o.found, ~|rsp_o.match_index, "miss index")
  `SHLU_ASSERT_NEXT(a_load_done, sts.accept && !sts.acc_lookup, ctl.out_load == sts.out_free, "load")

endmodule

`default_nettype wire
